[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, command codes and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

    typedef enum logic [1:0] {
        MODE_CW   = 2'd0,
        MODE_CCW  = 2'd1,
        MODE_STOP = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    localparam int unsigned HOLD_BASE = 10;
    localparam int unsigned HOLD_SPAN = 990;
    localparam int unsigned HOLD_DIV  = 260100;

    typedef logic [8:0] hold_t;
    typedef logic [3:0] coil_t;
    typedef logic [2:0] step_t;

    typedef struct packed {
        logic  stop;
        logic  ccw;
        hold_t hold;
    } sps_cmd_t;

    typedef hold_t hold_lut_t [256];
    typedef coil_t full_tab_t [4];
    typedef coil_t half_tab_t [8];

    localparam full_tab_t FULL_TABLE = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam half_tab_t HALF_TABLE = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    localparam step_t FULL_LAST_STEP = 3'd3;
    localparam step_t HALF_LAST_STEP = 3'd7;

    function automatic hold_lut_t build_hold_lut();
        hold_lut_t   lut;
        int unsigned prod;
        for (int i = 0; i < 256; i++) begin
            prod   = i * i * HOLD_SPAN;
            lut[i] = hold_t'(HOLD_BASE + prod / HOLD_DIV);
        end
        return lut;
    endfunction

    localparam hold_lut_t HOLD_LUT = build_hold_lut();

endpackage

[rtl/sps_front.sv]
// ----------------------------------------------------------------------------
// sps_front
// Accepts commands, classifies them and looks up the per-pattern hold time.
// ----------------------------------------------------------------------------
module sps_front
    import sps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_speed,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output sps_cmd_t cmd
);

    logic     valid_reg;
    logic     valid_next;
    sps_cmd_t cmd_reg;
    sps_cmd_t cmd_next;
    mode_t    mode;
    logic     take;

    assign mode    = mode_t'(s_mode);
    assign s_ready = !valid_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd_next = cmd_reg;
        if (take) begin
            unique case (mode)
                MODE_CW: begin
                    cmd_next.stop = 1'b0;
                    cmd_next.ccw  = 1'b0;
                    cmd_next.hold = HOLD_LUT[s_speed];
                end
                MODE_CCW: begin
                    cmd_next.stop = 1'b0;
                    cmd_next.ccw  = 1'b1;
                    cmd_next.hold = HOLD_LUT[s_speed];
                end
                default: begin
                    cmd_next.stop = 1'b1;
                    cmd_next.ccw  = 1'b0;
                    cmd_next.hold = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

[rtl/sps_queue.sv]
// ----------------------------------------------------------------------------
// sps_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sps_queue
    import sps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sps_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output sps_cmd_t out_cmd
);

    sps_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/sps_back.sv]
// ----------------------------------------------------------------------------
// sps_back
// Walks the queued command's coil table, one pattern per cycle unless stalled.
// ----------------------------------------------------------------------------
module sps_back
    import sps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       half_step_mode,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  sps_cmd_t   cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_coil_pattern,
    output logic [8:0] m_hold_ms,
    output logic       m_last
);

    step_t step_reg;
    step_t step_next;
    step_t last_step;
    step_t idx;
    logic  out_load;
    logic  emit;
    logic  final_pat;
    logic  valid_reg;
    coil_t coil_reg;
    coil_t coil_next;
    hold_t hold_reg;
    hold_t hold_next;
    logic  last_reg;
    logic  last_next;

    assign last_step = half_step_mode ? HALF_LAST_STEP : FULL_LAST_STEP;
    assign idx       = cmd.ccw ? (last_step - step_reg) : step_reg;
    assign out_load  = !valid_reg || m_ready;
    assign emit      = cmd_valid && out_load;
    assign final_pat = cmd.stop || (step_reg == last_step);
    assign cmd_ready = emit && final_pat;

    always_comb begin
        step_next = step_reg;
        if (emit) begin
            step_next = final_pat ? '0 : step_reg + 3'd1;
        end
    end

    always_comb begin
        coil_next = coil_reg;
        hold_next = hold_reg;
        last_next = last_reg;
        if (emit) begin
            last_next = final_pat;
            if (cmd.stop) begin
                coil_next = '0;
                hold_next = '0;
            end else begin
                coil_next = half_step_mode ? HALF_TABLE[idx] : FULL_TABLE[idx[1:0]];
                hold_next = cmd.hold;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            step_reg <= step_next;
            if (out_load) begin
                valid_reg <= cmd_valid;
            end
        end
        coil_reg <= coil_next;
        hold_reg <= hold_next;
        last_reg <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_coil_pattern = coil_reg;
    assign m_hold_ms      = hold_reg;
    assign m_last         = last_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= last_step)
        else $error("step index past end of table");

    a_pop_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |=> step_reg == '0)
        else $error("step index not rewound after command");

    a_stop_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && coil_reg == '0 |-> hold_reg == '0 && last_reg)
        else $error("all-off pattern with hold or without last");

endmodule

[rtl/stepper_phase_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_unit
// Turns rotate and stop commands into coil patterns with hold times.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   command | s_valid s_ready s_mode s_speed | in
//   pattern | m_valid m_ready m_coil_pattern | out
//           | m_hold_ms m_last               |
//   config  | cfg_valid cfg_ready cfg_data   | in
//
// A rotate command yields 4 patterns (full step) or 8 (half step), one per
// cycle from the pattern sequencer while m_ready is high; stop yields 1.
// The first pattern passes the front register, the queue and the output
// register. A two-entry queue lets commands enter while the sequencer runs.
// aresetn is synchronous and clears all valid flags and the step mode.
// m_ready low holds the output and backs up the queue, then s_ready.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_unit
    import sps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_speed,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_coil_pattern,
    output logic [8:0] m_hold_ms,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic     half_step_reg;
    logic     fr_valid;
    logic     fr_ready;
    sps_cmd_t fr_cmd;
    logic     q_valid;
    logic     q_ready;
    sps_cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_step_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            half_step_reg <= cfg_data;
        end
    end

    sps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_speed   (s_speed),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    sps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    sps_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .half_step_mode (half_step_reg),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_coil_pattern (m_coil_pattern),
        .m_hold_ms      (m_hold_ms),
        .m_last         (m_last)
    );

endmodule
